/* rtl/ordl_pkg.sv */
// Shared types and codes for the bounded ordered list.
package ordl_pkg;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned STATUS_W = 2;

	// Operation codes carried in the mode field
	localparam logic [MODE_W-1:0] MODE_INS_HEAD  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INS_TAIL  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REVERSE   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DUMP_FWD  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DUMP_BWD  = 3'd5;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

	// Command broadcast to every cell of the chain
	typedef enum logic [2:0] {
		OP_HOLD       = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_PUSH_BACK  = 3'd2,
		OP_REMOVE     = 3'd3,
		OP_ROT_FWD    = 3'd4,
		OP_ROT_BWD    = 3'd5
	} cell_op_t;

	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          position;
	} req_beat_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] item_value;
		logic [STATUS_W-1:0]       status;
		logic                      last;
	} rsp_beat_t;

endpackage

/* rtl/ordl_chan_if.sv */
// Valid/ready channel carrying one beat of a given payload type.
interface ordl_chan_if #(parameter type beat_t = logic) ();
	logic  valid;
	logic  ready;
	beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/bounded_ordered_list_top.sv */
// Top level of the bounded ordered list: control, output register and cell chain.
//
//  channel | dir | payload                          | beats per request
//  --------+-----+----------------------------------+-------------------------------
//  cmd     | in  | mode, value, position            | one
//  res     | out | item_value, status, last         | one, or one per element on dump
//
// Inserts, deletes, reverses and error cases answer with one response beat; a new
// request follows in the next cycle while the response register drains.
// A dump of N elements holds off requests until its last beat is out: it takes
// the request, then emits N beats. The chain rotates once per beat, paced by
// the single response register, and is back in order after the last.
// arst_n clears the element count, the reverse flag, the sequencer and the
// response valid; cell contents have no reset and are only read once written.
// res.ready low holds the response beat and stalls both new requests and dumps.
module bounded_ordered_list_top #(
	parameter int unsigned DEPTH = 32
) (
	input logic   clk,
	input logic   arst_n,
	ordl_chan_if.sink   cmd,
	ordl_chan_if.source res
);
	import ordl_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE = CW'(1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	state_t                    state_q, state_d;
	logic [CW-1:0]             count_q, count_d;
	logic                      rev_q, rev_d;
	logic [CW-1:0]             left_q, left_d;
	logic                      dump_fwd_q, dump_fwd_d;
	logic                      out_valid_q;
	rsp_beat_t                 out_q, out_d;
	logic                      emit;
	logic                      slot_free;
	logic                      accept;

	cell_op_t                  op;
	logic signed [VALUE_W-1:0] load_data;
	logic [IW-1:0]             phys_pos;
	logic [PW-1:0]             pos_ext;
	logic [PW-1:0]             cnt_ext;
	logic signed [VALUE_W-1:0] cell_val [DEPTH];
	logic signed [VALUE_W-1:0] head_val;
	logic signed [VALUE_W-1:0] tail_val;

	// The response register frees up when empty or when its beat is taken
	assign slot_free = !out_valid_q || res.ready;
	assign cmd.ready = (state_q == S_IDLE) && slot_free;
	assign accept    = cmd.valid && cmd.ready;

	assign head_val = cell_val[0];
	assign tail_val = cell_val[IW'(count_q - ONE)];

	// Map the 1-based logical position onto a physical cell index
	assign pos_ext  = PW'(cmd.data.position);
	assign cnt_ext  = PW'(count_q);
	assign phys_pos = rev_q ? IW'(cnt_ext - pos_ext) : IW'(pos_ext - PW'(1));

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		rev_d      = rev_q;
		left_d     = left_q;
		dump_fwd_d = dump_fwd_q;
		op         = OP_HOLD;
		load_data  = cmd.data.value;
		emit       = 1'b0;
		out_d      = '{item_value: '0, status: ST_OK, last: 1'b1};

		if (state_q == S_IDLE) begin
			if (accept) begin
				emit = 1'b1;
				case (cmd.data.mode)
					MODE_INS_HEAD, MODE_INS_TAIL: begin
						if (count_q == FULL_COUNT) begin
							out_d.status = ST_FULL;
						end else begin
							// Logical head sits at the physical front unless reversed
							op = ((cmd.data.mode == MODE_INS_HEAD) == !rev_q) ?
								OP_PUSH_FRONT : OP_PUSH_BACK;
							count_d = count_q + ONE;
						end
					end
					MODE_DELETE: begin
						if (count_q == '0) begin
							out_d.status = ST_EMPTY;
						end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
							out_d.status = ST_BADPOS;
						end else begin
							op      = OP_REMOVE;
							count_d = count_q - ONE;
						end
					end
					MODE_REVERSE: begin
						if (count_q > ONE) begin
							rev_d = !rev_q;
						end
					end
					MODE_DUMP_FWD, MODE_DUMP_BWD: begin
						if (count_q == '0) begin
							out_d.status = ST_EMPTY;
						end else begin
							// Hand over to the dump sequencer; no beat this cycle
							emit       = 1'b0;
							state_d    = S_DUMP;
							left_d     = count_q;
							dump_fwd_d = (cmd.data.mode == MODE_DUMP_FWD) == !rev_q;
						end
					end
					default: begin
						out_d.status = ST_OK;
					end
				endcase
			end
		end else begin
			if (slot_free) begin
				// Emit the element at the read end and rotate it to the other end
				emit             = 1'b1;
				out_d.item_value = dump_fwd_q ? head_val : tail_val;
				out_d.last       = (left_q == ONE);
				op               = dump_fwd_q ? OP_ROT_FWD : OP_ROT_BWD;
				load_data        = dump_fwd_q ? head_val : tail_val;
				left_d           = left_q - ONE;
				if (left_q == ONE) begin
					state_d = S_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rev_q       <= 1'b0;
			left_q      <= '0;
			dump_fwd_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			rev_q      <= rev_d;
			left_q     <= left_d;
			dump_fwd_q <= dump_fwd_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Response payload: load only when a new beat is produced
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= out_d;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	// Cell chain: each cell sees its left and right neighbor
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [VALUE_W-1:0] left_n;
		logic signed [VALUE_W-1:0] right_n;

		if (g == 0) begin : g_front
			assign left_n = load_data;
		end else begin : g_mid_l
			assign left_n = cell_val[g-1];
		end

		if (g == DEPTH - 1) begin : g_back
			assign right_n = load_data;
		end else begin : g_mid_r
			assign right_n = cell_val[g+1];
		end

		ordl_cell #(
			.DEPTH (DEPTH),
			.IDX   (g)
		) u_cell (
			.clk       (clk),
			.op        (op),
			.count     (count_q),
			.pos       (phys_pos),
			.load_data (load_data),
			.left_val  (left_n),
			.right_val (right_n),
			.val       (cell_val[g])
		);
	end

	// Element count never exceeds the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("element count above capacity");

	// No request is taken while a dump is in progress
	a_no_accept_dump: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |-> !cmd.ready)
		else $error("request accepted during dump");

	// A dump always has elements left to emit
	a_dump_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |-> left_q != '0 && left_q <= count_q)
		else $error("dump counter out of range");

	// Emitting the final dump beat returns to idle with the count unchanged
	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP && slot_free && left_q == ONE |=>
			state_q == S_IDLE && res.valid && res.data.last && $stable(count_q))
		else $error("dump did not finish cleanly");

endmodule

/* rtl/ordl_cell.sv */
// One storage cell of the list chain; picks its next value from its neighbors.
module ordl_cell #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned IDX   = 0
) (
	input  logic                                        clk,
	input  ordl_pkg::cell_op_t                          op,
	input  logic [$clog2(DEPTH+1)-1:0]                  count,
	input  logic [$clog2(DEPTH)-1:0]                    pos,
	input  logic signed [ordl_pkg::VALUE_W-1:0]         load_data,
	input  logic signed [ordl_pkg::VALUE_W-1:0]         left_val,
	input  logic signed [ordl_pkg::VALUE_W-1:0]         right_val,
	output logic signed [ordl_pkg::VALUE_W-1:0]         val
);
	import ordl_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = $clog2(DEPTH);
	localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
	localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);
	localparam logic [IW-1:0] MY_POS  = IW'(IDX);
	localparam bit IS_FRONT = (IDX == 0);

	logic signed [VALUE_W-1:0] val_q;
	logic signed [VALUE_W-1:0] val_d;

	always_comb begin
		val_d = val_q;
		case (op)
			OP_PUSH_FRONT: begin
				val_d = IS_FRONT ? load_data : left_val;
			end
			OP_PUSH_BACK: begin
				if (MY_IDX == count) begin
					val_d = load_data;
				end
			end
			OP_REMOVE: begin
				if (MY_POS >= pos && NEXT_IDX < count) begin
					val_d = right_val;
				end
			end
			OP_ROT_FWD: begin
				if (NEXT_IDX < count) begin
					val_d = right_val;
				end else if (NEXT_IDX == count) begin
					val_d = load_data;
				end
			end
			OP_ROT_BWD: begin
				if (IS_FRONT) begin
					val_d = load_data;
				end else if (MY_IDX < count) begin
					val_d = left_val;
				end
			end
			default: begin
				val_d = val_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign val = val_q;

endmodule

/* tb/sv/ordl_list_checker.sv */
`timescale 1ns / 1ps
// Checker for the bounded ordered list: list predictor and result comparison.
module ordl_list_checker #(
	parameter int unsigned DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  logic                cmd_ready,
	input  ordl_pkg::req_beat_t cmd_data,
	input  logic                res_valid,
	input  logic                res_ready,
	input  ordl_pkg::rsp_beat_t res_data,
	output int unsigned         mismatches,
	output int unsigned         outstanding
);
	import ordl_pkg::*;

	// Predicted list: physical cells, element count and direction flag
	logic signed [VALUE_W-1:0] cells [DEPTH];
	int unsigned               fill;
	logic                      flipped;
	rsp_beat_t                 expected_beats [$];
	int unsigned               fail_count;

	function automatic int unsigned phys_index(input int unsigned li);
		return flipped ? fill - 1 - li : li;
	endfunction

	// Advance the predicted list by one request and queue the beats it causes.
	task automatic apply_request(input req_beat_t rq);
		rsp_beat_t   beat;
		int unsigned li;
		beat.item_value = '0;
		beat.status     = ST_OK;
		beat.last       = 1'b1;
		case (rq.mode)
			MODE_INS_HEAD, MODE_INS_TAIL: begin
				if (fill >= DEPTH) begin
					beat.status = ST_FULL;
				end else begin
					if ((rq.mode == MODE_INS_HEAD) == !flipped) begin
						for (int i = fill; i > 0; i--) cells[i] = cells[i-1];
						cells[0] = rq.value;
					end else begin
						cells[fill] = rq.value;
					end
					fill++;
				end
				expected_beats.push_back(beat);
			end
			MODE_DELETE: begin
				if (fill == 0) begin
					beat.status = ST_EMPTY;
				end else if (rq.position == 0 || rq.position > fill) begin
					beat.status = ST_BADPOS;
				end else begin
					for (int i = phys_index(rq.position - 1); i + 1 < fill; i++)
						cells[i] = cells[i+1];
					fill--;
				end
				expected_beats.push_back(beat);
			end
			MODE_REVERSE: begin
				if (fill > 1) flipped = !flipped;
				expected_beats.push_back(beat);
			end
			MODE_DUMP_FWD, MODE_DUMP_BWD: begin
				if (fill == 0) begin
					beat.status = ST_EMPTY;
					expected_beats.push_back(beat);
				end else begin
					for (int unsigned i = 0; i < fill; i++) begin
						li = (rq.mode == MODE_DUMP_FWD) ? i : fill - 1 - i;
						beat.item_value = cells[phys_index(li)];
						beat.last       = (i + 1 == fill);
						expected_beats.push_back(beat);
					end
				end
			end
			default: expected_beats.push_back(beat);
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_beat_t want;
		if (!arst_n) begin
			fill        = 0;
			flipped     = 1'b0;
			fail_count  = 0;
			expected_beats.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// Check the result beat first: a request taken at this edge
			// cannot have produced it.
			if (res_valid && res_ready) begin
				if (expected_beats.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result beat value=%0d status=%0d last=%0b",
							$realtime, res_data.item_value, res_data.status, res_data.last);
				end else begin
					want = expected_beats.pop_front();
					if (res_data.item_value !== want.item_value ||
					    res_data.status !== want.status || res_data.last !== want.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: result beat differs: expected value=%0d status=%0d ",
								$realtime, want.item_value, want.status,
								"last=%0b, got value=%0d status=%0d last=%0b", want.last,
								res_data.item_value, res_data.status, res_data.last);
					end
				end
			end
			if (cmd_valid && cmd_ready) apply_request(cmd_data);
			mismatches  <= fail_count;
			outstanding <= expected_beats.size();
		end
	end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Stimulus, reset, clock and verdict for the bounded ordered list testbench.
module tb_top;
	import ordl_pkg::*;

	localparam int unsigned DEPTH = 32;

	// Mode codes the block does not use; it must answer them with a plain ok
	localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        calm;         // high: neither side idles
	int unsigned mismatches;
	int unsigned outstanding;  // result beats predicted but not yet seen

	ordl_chan_if #(.beat_t(req_beat_t)) cmd_if ();
	ordl_chan_if #(.beat_t(rsp_beat_t)) res_if ();

	bounded_ordered_list_top #(.DEPTH(DEPTH)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if)
	);

	// The checker sees both channels, predicts the list and compares beats.
	ordl_list_checker #(.DEPTH(DEPTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_if.valid),
		.cmd_ready   (cmd_if.ready),
		.cmd_data    (cmd_if.data),
		.res_valid   (res_if.valid),
		.res_ready   (res_if.ready),
		.res_data    (res_if.data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver side: drop ready in about 11 percent of cycles, unless calm.
	always @(posedge clk) begin
		res_if.ready <= calm || ($urandom_range(0, 99) >= 11);
	end

	// Present one request beat and hold it until the block takes it. Random
	// idle cycles go in front of the beat so gaps land on every phase of the
	// block's work; valid stays high between back-to-back beats.
	task automatic send_cmd(input logic [MODE_W-1:0] m, input logic signed [VALUE_W-1:0] v,
			input logic [POS_W-1:0] p);
		req_beat_t rq;
		rq.mode     = m;
		rq.value    = v;
		rq.position = p;
		while (!calm && $urandom_range(0, 99) < 11) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.data  <= rq;
		do @(posedge clk); while (!cmd_if.ready);
	endtask

	// One random request. ins_pct and del_pct weight inserts and deletes; the
	// rest is reverses, dumps and the occasional unused mode.
	task automatic send_random(input int unsigned ins_pct, input int unsigned del_pct);
		int unsigned               roll;
		logic [MODE_W-1:0]         m;
		logic [POS_W-1:0]          p;
		logic signed [VALUE_W-1:0] v;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct) begin
			m = $urandom_range(0, 1) ? MODE_INS_TAIL : MODE_INS_HEAD;
		end else if (roll < ins_pct + del_pct) begin
			m = MODE_DELETE;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 30)      m = MODE_REVERSE;
			else if (roll < 60) m = MODE_DUMP_FWD;
			else if (roll < 92) m = MODE_DUMP_BWD;
			else                m = $urandom_range(0, 1) ? MODE_SPARE_B : MODE_SPARE_A;
		end
		// Favor positions near the front, still reach deep ones and the
		// whole field, including zero and values past any possible count.
		roll = $urandom_range(0, 99);
		if (roll < 50)      p = POS_W'($urandom_range(1, 4));
		else if (roll < 88) p = POS_W'($urandom_range(1, DEPTH));
		else                p = POS_W'($urandom_range(0, 63));
		v = $urandom;
		send_cmd(m, v, p);
	endtask

	// Lower valid and hold until every predicted beat has come back.
	task automatic drain_results();
		cmd_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		arst_n       <= 1'b0;
		calm         <= 1'b0;
		cmd_if.valid <= 1'b0;
		cmd_if.data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list in every mode that can see it
		send_cmd(MODE_DUMP_FWD, 32'sd5, 6'd1);
		send_cmd(MODE_DUMP_BWD, 32'sd0, 6'd0);
		send_cmd(MODE_DELETE, 32'sd0, 6'd1);
		send_cmd(MODE_REVERSE, 32'sd0, 6'd0);
		// Single element: bad positions, reverse is a no-op, delete it at one
		send_cmd(MODE_INS_HEAD, 32'sh7FFF_FFFF, 6'h3F);
		send_cmd(MODE_DELETE, 32'sd0, 6'd2);
		send_cmd(MODE_DELETE, 32'sd0, 6'd0);
		send_cmd(MODE_REVERSE, 32'sd0, 6'd0);
		send_cmd(MODE_DUMP_BWD, 32'sd0, 6'd0);
		send_cmd(MODE_DELETE, 32'sd0, 6'd1);
		// A few elements with the extreme values, both directions, reversed
		send_cmd(MODE_INS_TAIL, 32'sh8000_0000, 6'd0);
		send_cmd(MODE_INS_HEAD, 32'sd0, 6'd0);
		send_cmd(MODE_INS_TAIL, -32'sd1, 6'h3F);
		send_cmd(MODE_INS_HEAD, 32'sh7FFF_FFFF, 6'd0);
		send_cmd(MODE_DUMP_FWD, 32'sd0, 6'd0);
		send_cmd(MODE_REVERSE, 32'sd0, 6'd0);
		send_cmd(MODE_DUMP_FWD, 32'sd0, 6'd0);
		send_cmd(MODE_INS_HEAD, 32'sh5555_AAAA, 6'd0);
		send_cmd(MODE_DELETE, 32'sd0, 6'h3F);
		send_cmd(MODE_DELETE, 32'sd0, 6'd2);
		send_cmd(MODE_DUMP_BWD, 32'sd0, 6'd0);
		// Unused modes, one with every bit of value and position set, one with alternating bits
		send_cmd(MODE_SPARE_A, -32'sd1, 6'h3F);
		send_cmd(MODE_SPARE_B, 32'sh2AAA_5555, 6'h15);

		// Random mix that keeps the list at moderate length
		repeat (90) send_random(45, 20);

		// Hold off the sender until the block has answered everything
		drain_results();

		// Fill past capacity with no idling on either side, then dump and
		// reverse a full list
		calm <= 1'b1;
		repeat (40) send_random(100, 0);
		repeat (8) send_random(0, 0);
		calm <= 1'b0;

		repeat (90) send_random(35, 25);
		// Delete-heavy stretch walks the list back toward empty
		repeat (50) send_random(0, 85);
		repeat (40) send_random(40, 20);

		// Wait out the last results, then give the block time for strays
		drain_results();
		repeat (40) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("bounded_ordered_list_top: match");
		end else begin
			$display("bounded_ordered_list_top: mismatch");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("bounded_ordered_list_top: mismatch");
		$finish;
	end

endmodule
